// ===== hw/rtl/crc_fr_pkg.sv =====
`default_nettype none

package crc_fr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CRC_W      = 16;
   localparam int unsigned INDEX_W    = 9;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET = 8'd170;
   localparam logic [BYTE_W-1:0] MAX_LEN_RESET   = 8'd254;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_BYTE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN   = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_NONE         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LEN_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FRAME_READY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CRC_MISMATCH = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload_len;
      logic                data_valid;
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   data_index;
   } rsp_type;

   // CRC-16/MODBUS, one byte, reflected
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc_frame_receiver.sv =====
`default_nettype none

// Length-prefixed frame receiver with CRC-16/MODBUS check. Each accepted
// request carries one received byte and yields exactly one response. The
// receiver hunts for the configured sync byte, takes a length byte (lengths
// above the max_len register are answered with "length rejected" and the hunt
// resumes), then passes each payload byte out with its index, and finally
// compares the two-byte little-endian CRC against the CRC run over the payload
// (init 0xFFFF, reflected poly 0xA001, no final xor), answering "frame ready"
// or "crc mismatch" with the payload length. A start byte inside a frame is
// plain data. Throughput is one byte per clock while req_stall is low: the
// frame state and the byte-wide CRC update sit between the request port and
// a response register, and a one-entry skid buffer behind that register
// lets a request be taken while a response is still waiting. req_stall rises
// only when both the response register and the skid entry are full.
// Register writes are intended while the block is idle.
module crc_frame_receiver (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [crc_fr_pkg::BYTE_W-1:0]     req_rx_byte,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [crc_fr_pkg::STATUS_W-1:0]        rsp_status,
   output logic [crc_fr_pkg::BYTE_W-1:0]          rsp_payload_len,
   output logic                                   rsp_data_valid,
   output logic [crc_fr_pkg::BYTE_W-1:0]          rsp_data_byte,
   output logic [crc_fr_pkg::BYTE_W-1:0]          rsp_data_index,
   // configuration
   input  wire logic                              csr_we,
   input  wire logic [crc_fr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [crc_fr_pkg::BYTE_W-1:0]     csr_wdata
);
   import crc_fr_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // configuration registers
   logic [BYTE_W-1:0] sync_byte_ff;
   logic [BYTE_W-1:0] max_len_ff;

   // frame state
   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  frame_len_ff, frame_len_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [BYTE_W-1:0]  crc_low_ff, crc_low_in;

   // response register and skid entry
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   rsp_type res;
   logic    accept;
   logic    out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   // response register can load this cycle
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff <= SYNC_BYTE_RESET;
         max_len_ff   <= MAX_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_BYTE: sync_byte_ff <= csr_wdata;
            CSR_MAX_LEN:   max_len_ff   <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // frame decode for the byte at the port
   always_comb begin
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      index_in     = index_ff;
      crc_in       = crc_ff;
      crc_low_in   = crc_low_ff;
      res          = '0;
      res.status   = ST_NONE;
      if (accept) begin
         case (phase_ff)
            PH_LENGTH: begin
               frame_len_in = req_rx_byte;
               if (req_rx_byte <= max_len_ff) begin
                  index_in = '0;
                  crc_in   = CRC_INIT;
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in   = PH_HUNT;
                  res.status = ST_LEN_REJECTED;
               end
            end
            PH_PAYLOAD: begin
               if (index_ff < {1'b0, frame_len_ff}) begin
                  // payload byte
                  res.data_valid = 1'b1;
                  res.data_byte  = req_rx_byte;
                  res.data_index = index_ff[BYTE_W-1:0];
                  crc_in         = crc_byte(crc_ff, req_rx_byte);
                  index_in       = index_ff + INDEX_W'(1);
               end else if (index_ff == {1'b0, frame_len_ff}) begin
                  // CRC low byte
                  crc_low_in = req_rx_byte;
                  index_in   = index_ff + INDEX_W'(1);
               end else begin
                  // CRC high byte closes the frame
                  phase_in        = PH_HUNT;
                  res.payload_len = frame_len_ff;
                  res.status      = ({req_rx_byte, crc_low_ff} == crc_ff) ?
                                    ST_FRAME_READY : ST_CRC_MISMATCH;
               end
            end
            PH_HUNT: begin
               phase_in = (req_rx_byte == sync_byte_ff) ? PH_LENGTH : PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // response register with skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         frame_len_ff  <= '0;
         index_ff      <= '0;
         crc_ff        <= CRC_INIT;
         crc_low_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         frame_len_ff  <= frame_len_in;
         index_ff      <= index_in;
         crc_ff        <= crc_in;
         crc_low_ff    <= crc_low_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_payload_len = out_ff.payload_len;
   assign rsp_data_valid  = out_ff.data_valid;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_data_index  = out_ff.data_index;

endmodule

`default_nettype wire

// ===== hw/rtl/crc_fr_checker.sv =====
`default_nettype none

module crc_fr_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [crc_fr_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [crc_fr_pkg::BYTE_W-1:0]     rsp_payload_len,
   input wire logic                              rsp_data_valid,
   input wire logic [crc_fr_pkg::BYTE_W-1:0]     rsp_data_byte,
   input wire logic [crc_fr_pkg::BYTE_W-1:0]     rsp_data_index
);
   import crc_fr_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_payload_len) && $stable(rsp_data_valid) &&
         $stable(rsp_data_byte) && $stable(rsp_data_index))
      else $error("stalled response changed");

   // a payload byte never carries a frame status
   a_data_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_status == ST_NONE && rsp_payload_len == '0)
      else $error("payload byte with status");

   // length only reported at frame end
   a_len_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FRAME_READY && rsp_status != ST_CRC_MISMATCH
         |-> rsp_payload_len == '0)
      else $error("payload length outside frame end");

   // data fields zero without a payload byte
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |-> rsp_data_byte == '0 && rsp_data_index == '0)
      else $error("data fields set without payload byte");

endmodule

bind crc_frame_receiver crc_fr_checker u_crc_fr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_payload_len (rsp_payload_len),
   .rsp_data_valid  (rsp_data_valid),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_data_index  (rsp_data_index)
);

`default_nettype wire
